// ===== hdl/rv32i_instruction_execute_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef RV32I_INSTRUCTION_EXECUTE_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTE_MACROS_SVH

// Assert an implication, checked on every rising clock edge outside reset.
`define RVX_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert an implication that is also checked while reset is asserted.
`define RVX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg: shared types and constants
// Payload structs, opcode codes and the decoded-instruction struct that
// passes from the front end to the execute back end.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int WORD_AW = MEM_AW - 2;

  typedef enum logic [1:0] {
    OPN_WRITE = 2'd0,
    OPN_EXEC = 2'd1,
    OPN_READ = 2'd2,
    OPN_NONE = 2'd3
  } opn_t;

  localparam logic [6:0] OPC_LUI = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam logic [6:0] OPC_JAL = 7'h6f;
  localparam logic [6:0] OPC_JALR = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD = 7'h03;
  localparam logic [6:0] OPC_STORE = 7'h23;
  localparam logic [6:0] OPC_IMM = 7'h13;
  localparam logic [6:0] OPC_REG = 7'h33;
  localparam logic [6:0] F7_ALT = 7'h20;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    K_NOP, K_MWRITE, K_MREAD, K_ILL, K_LUI, K_AUIPC, K_JAL, K_JALR,
    K_BRANCH, K_LOAD, K_STORE, K_ALU
  } kind_t;

  typedef enum logic [3:0] {
    A_ADD, A_SUB, A_SLL, A_SLT, A_SLTU, A_XOR, A_SRL, A_SRA, A_OR, A_AND
  } aluop_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [31:0] instruction;
    logic [11:0] mem_address;
    logic [31:0] mem_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic reg_write;
    logic [4:0] dest_reg;
    logic [31:0] dest_value;
    logic [31:0] read_word;
    logic [1:0] status;
  } out_item_t;

  // Decoded instruction handed from front end to back end.
  typedef struct packed {
    kind_t kind;
    aluop_t aluop;
    logic use_imm;
    logic [2:0] f3;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic [31:0] imm;
    logic [31:0] mword;
  } dec_t;

  function automatic logic [31:0] sext12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

endpackage

// ===== hdl/rvx_decode.sv =====
// ----------------------------------------------------------------------------
// rvx_decode: front end
// Accepts input transactions, classifies and decodes them, and writes the
// result into the decoded-item queue.
// ----------------------------------------------------------------------------
module rvx_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rvx_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output rvx_pkg::dec_t     q_data
);
  import rvx_pkg::*;

  localparam int QD = 2;

  dec_t q_mem_r [QD];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  dec_t d;
  logic [31:0] ir;
  logic [6:0] opc, f7;
  logic [2:0] f3;
  logic push, pop;

  assign ir = in_data.instruction;
  assign opc = ir[6:0];
  assign f3 = ir[14:12];
  assign f7 = ir[31:25];

  always_comb begin
    d = '0;
    d.kind = K_ILL;
    d.aluop = A_ADD;
    d.f3 = f3;
    d.rd = ir[11:7];
    d.rs1 = ir[19:15];
    d.rs2 = ir[24:20];
    d.mword = in_data.mem_word;
    case (opn_t'(in_data.operation))
      OPN_WRITE: begin
        d.kind = K_MWRITE;
        d.imm = {{(32-12){1'b0}}, in_data.mem_address};
      end
      OPN_READ: begin
        d.kind = K_MREAD;
        d.imm = {{(32-12){1'b0}}, in_data.mem_address};
      end
      OPN_NONE: d.kind = K_NOP;
      default: begin
        case (opc)
          OPC_LUI: begin
            d.kind = K_LUI;
            d.imm = {ir[31:12], 12'h000};
          end
          OPC_AUIPC: begin
            d.kind = K_AUIPC;
            d.imm = {ir[31:12], 12'h000};
          end
          OPC_JAL: begin
            d.kind = K_JAL;
            d.imm = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
          end
          OPC_JALR: begin
            d.kind = (f3 == 3'd0) ? K_JALR : K_ILL;
            d.imm = sext12(ir[31:20]);
          end
          OPC_BRANCH: begin
            d.kind = (f3 == 3'd2 || f3 == 3'd3) ? K_ILL : K_BRANCH;
            d.imm = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
          end
          OPC_LOAD: begin
            d.kind = (f3 == 3'd3 || f3 > 3'd5) ? K_ILL : K_LOAD;
            d.imm = sext12(ir[31:20]);
          end
          OPC_STORE: begin
            d.kind = (f3 > 3'd2) ? K_ILL : K_STORE;
            d.imm = sext12({ir[31:25], ir[11:7]});
          end
          OPC_IMM: begin
            d.kind = K_ALU;
            d.use_imm = 1'b1;
            d.imm = sext12(ir[31:20]);
            case (f3)
              3'd0: d.aluop = A_ADD;
              3'd1: begin
                d.aluop = A_SLL;
                d.imm = {27'd0, ir[24:20]};
                if (f7 != 7'd0) d.kind = K_ILL;
              end
              3'd2: d.aluop = A_SLT;
              3'd3: d.aluop = A_SLTU;
              3'd4: d.aluop = A_XOR;
              3'd5: begin
                d.aluop = (f7 == F7_ALT) ? A_SRA : A_SRL;
                d.imm = {27'd0, ir[24:20]};
                if (f7 != 7'd0 && f7 != F7_ALT) d.kind = K_ILL;
              end
              3'd6: d.aluop = A_OR;
              default: d.aluop = A_AND;
            endcase
          end
          OPC_REG: begin
            d.kind = K_ALU;
            case (f3)
              3'd0: d.aluop = (f7 == F7_ALT) ? A_SUB : A_ADD;
              3'd1: d.aluop = A_SLL;
              3'd2: d.aluop = A_SLT;
              3'd3: d.aluop = A_SLTU;
              3'd4: d.aluop = A_XOR;
              3'd5: d.aluop = (f7 == F7_ALT) ? A_SRA : A_SRL;
              3'd6: d.aluop = A_OR;
              default: d.aluop = A_AND;
            endcase
            if (f7 != 7'd0 && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
              d.kind = K_ILL;
          end
          default: d.kind = K_ILL;
        endcase
      end
    endcase
  end

  assign in_ready = (q_cnt_r != 2'(QD));
  assign push = in_valid && in_ready;
  assign q_valid = (q_cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[q_wp_r] <= d;
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/rvx_execute.sv =====
// ----------------------------------------------------------------------------
// rvx_execute: back end
// Two-step sequencer: register file and byte-banked memory read, then
// execute, write back and register the result.
// ----------------------------------------------------------------------------
module rvx_execute (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  rvx_pkg::dec_t      q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rvx_pkg::out_item_t out_data
);
  import rvx_pkg::*;

  typedef enum logic {S_RD, S_EX} state_t;

  state_t state_r;
  dec_t cur_r;
  logic [31:0] pc_r;
  logic [31:0] rf_r [32];
  logic [31:0] a_r, b_r;
  logic [7:0] bank0 [MEM_WORDS];
  logic [7:0] bank1 [MEM_WORDS];
  logic [7:0] bank2 [MEM_WORDS];
  logic [7:0] bank3 [MEM_WORDS];
  logic [7:0] rb_r [4];
  logic [1:0] rlo_r;
  logic rng_r;
  logic out_valid_r;
  out_item_t out_r;

  // read-stage address of the access
  logic [31:0] ea;
  logic [2:0] sz;
  logic [WORD_AW-1:0] wi [4];
  logic [WORD_AW:0] wsum [4];
  logic in_rng;
  logic [31:0] ra, rb;

  assign ra = (q_data.rs1 == 5'd0) ? 32'd0 : rf_r[q_data.rs1];
  assign rb = (q_data.rs2 == 5'd0) ? 32'd0 : rf_r[q_data.rs2];

  always_comb begin
    case (q_data.kind)
      K_MWRITE, K_MREAD: begin
        ea = q_data.imm;
        sz = 3'd4;
      end
      default: begin
        ea = ra + q_data.imm;
        sz = (q_data.f3[1:0] == 2'd0) ? 3'd1 : ((q_data.f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
      end
    endcase
    in_rng = (ea <= 32'(MEM_BYTES) - {29'd0, sz});
    for (int i = 0; i < 4; i++) begin
      // word row holding byte lane i of the access
      wsum[i] = {1'b0, ea[MEM_AW-1:2]} + {{WORD_AW{1'b0}}, (2'(i) < ea[1:0])};
      wi[i] = wsum[i][WORD_AW-1:0];
    end
  end

  // execute-stage values
  logic [31:0] a, b, opb, alu, ldv, res_val, npc, wdata, rw;
  logic [31:0] mraw;
  logic wr, take, do_st;
  logic [1:0] st;
  logic [7:0] lane_b [4];
  logic [1:0] lane_k [4];
  logic [3:0] lane_we;
  logic [WORD_AW-1:0] wwi [4];
  logic [WORD_AW:0] wwsum [4];
  logic [31:0] ea_x;
  logic [2:0] sz_x;

  assign a = a_r;
  assign b = b_r;
  assign opb = cur_r.use_imm ? cur_r.imm : b;

  always_comb begin
    case (cur_r.aluop)
      A_ADD: alu = a + opb;
      A_SUB: alu = a - opb;
      A_SLL: alu = a << opb[4:0];
      A_SLT: alu = {31'd0, $signed(a) < $signed(opb)};
      A_SLTU: alu = {31'd0, a < opb};
      A_XOR: alu = a ^ opb;
      A_SRL: alu = a >> opb[4:0];
      A_SRA: alu = 32'($signed(a) >>> opb[4:0]);
      A_OR: alu = a | opb;
      A_AND: alu = a & opb;
      default: alu = a + opb;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) mraw[8*i +: 8] = rb_r[2'(i) + rlo_r];
    case (cur_r.f3)
      3'd0: ldv = {{24{mraw[7]}}, mraw[7:0]};
      3'd1: ldv = {{16{mraw[15]}}, mraw[15:0]};
      3'd4: ldv = {24'd0, mraw[7:0]};
      3'd5: ldv = {16'd0, mraw[15:0]};
      default: ldv = mraw;
    endcase
    if (!rng_r) ldv = 32'd0;
  end

  always_comb begin
    case (cur_r.f3)
      3'd0: take = (a == b);
      3'd1: take = (a != b);
      3'd4: take = ($signed(a) < $signed(b));
      3'd5: take = !($signed(a) < $signed(b));
      3'd6: take = (a < b);
      default: take = (a >= b);
    endcase
  end

  always_comb begin
    npc = pc_r + 32'd4;
    wr = 1'b0;
    res_val = 32'd0;
    rw = 32'd0;
    st = ST_OK;
    do_st = 1'b0;
    wdata = b;
    case (cur_r.kind)
      K_MWRITE: begin
        npc = pc_r;
        wdata = cur_r.mword;
        if (rng_r) do_st = 1'b1;
        else st = ST_RANGE;
      end
      K_MREAD: begin
        npc = pc_r;
        if (rng_r) rw = mraw;
        else st = ST_RANGE;
      end
      K_NOP: npc = pc_r;
      K_ILL: st = ST_ILLEGAL;
      K_LUI: begin
        wr = 1'b1;
        res_val = cur_r.imm;
      end
      K_AUIPC: begin
        wr = 1'b1;
        res_val = pc_r + cur_r.imm;
      end
      K_JAL: begin
        wr = 1'b1;
        res_val = pc_r + 32'd4;
        npc = pc_r + cur_r.imm;
      end
      K_JALR: begin
        wr = 1'b1;
        res_val = pc_r + 32'd4;
        npc = (a + cur_r.imm) & ~32'd1;
      end
      K_BRANCH: if (take) npc = pc_r + cur_r.imm;
      K_LOAD: begin
        wr = 1'b1;
        res_val = ldv;
        if (!rng_r) st = ST_RANGE;
      end
      K_STORE: begin
        if (rng_r) do_st = 1'b1;
        else st = ST_RANGE;
      end
      K_ALU: begin
        wr = 1'b1;
        res_val = alu;
      end
      default: st = ST_ILLEGAL;
    endcase
    if (cur_r.rd == 5'd0) wr = 1'b0;
    if (!wr) res_val = 32'd0;
  end

  // store lanes
  always_comb begin
    if (cur_r.kind == K_MWRITE) begin
      ea_x = cur_r.imm;
      sz_x = 3'd4;
    end else begin
      ea_x = a + cur_r.imm;
      sz_x = (cur_r.f3[1:0] == 2'd0) ? 3'd1 : ((cur_r.f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
    end
    for (int i = 0; i < 4; i++) begin
      wwsum[i] = {1'b0, ea_x[MEM_AW-1:2]} + {{WORD_AW{1'b0}}, (2'(i) < ea_x[1:0])};
      wwi[i] = wwsum[i][WORD_AW-1:0];
      // lane i holds byte k of the data where k = i - ea[1:0]
      lane_k[i] = 2'(i) - ea_x[1:0];
      lane_b[i] = wdata[{lane_k[i], 3'b000} +: 8];
      lane_we[i] = do_st && ({1'b0, lane_k[i]} < sz_x);
    end
  end

  logic fire;
  assign fire = (state_r == S_EX) && (!out_valid_r || out_ready);
  assign q_ready = (state_r == S_RD);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      rb_r[0] <= bank0[wi[0]];
      rb_r[1] <= bank1[wi[1]];
      rb_r[2] <= bank2[wi[2]];
      rb_r[3] <= bank3[wi[3]];
    end
    if (fire) begin
      if (lane_we[0]) bank0[wwi[0]] <= lane_b[0];
      if (lane_we[1]) bank1[wwi[1]] <= lane_b[1];
      if (lane_we[2]) bank2[wwi[2]] <= lane_b[2];
      if (lane_we[3]) bank3[wwi[3]] <= lane_b[3];
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur_r <= q_data;
      a_r <= ra;
      b_r <= rb;
      rlo_r <= ea[1:0];
      rng_r <= in_rng;
    end
    if (fire) out_r <= '{npc, wr, wr ? cur_r.rd : 5'd0, res_val, rw, st};
    if (!rst_n) begin
      state_r <= S_RD;
      out_valid_r <= 1'b0;
      pc_r <= 32'd0;
      for (int i = 0; i < 32; i++) rf_r[i] <= 32'd0;
    end else begin
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_RD: if (q_valid) state_r <= S_EX;
        S_EX: if (fire) begin
          state_r <= S_RD;
          pc_r <= npc;
          if (wr) rf_r[cur_r.rd] <= res_val;
        end
        default: state_r <= S_RD;
      endcase
    end
  end

endmodule

// ===== hdl/rv32i_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_execute: RV32I executor with byte-banked data memory
// Front end decodes transactions into a two-entry queue; the back end
// executes them against the register file, PC and data memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals
//  in_      input      in_valid, in_ready, in_data (operation/instruction/...)
//  out_     output     out_valid, out_ready, out_data (next_pc ... status)
//
//  Each transaction passes through a read step (register file and the four
//  byte banks, read registered) and then an execute/write-back step; the back
//  end takes no new item until it has executed the last one.
//  rst_n is synchronous: it clears the queue, PC and register file; memory
//  contents are undefined until written. The queue lets the front end accept
//  while the back end waits on out_ready.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rvx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rvx_pkg::out_item_t out_data
);
  import rvx_pkg::*;

  // decoded-item queue between front and back end
  logic q_valid, q_ready;
  dec_t q_data;

  rvx_decode u_decode (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  rvx_execute u_execute (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ===== hdl/rvx_checker.sv =====
// ----------------------------------------------------------------------------
// rvx_checker: port-level checks
// Observes the top-level ports only.
// ----------------------------------------------------------------------------
`include "rv32i_instruction_execute_macros.svh"
module rvx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input rvx_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input rvx_pkg::out_item_t out_data
);
  import rvx_pkg::*;

  `RVX_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "out_valid after reset")
  `RVX_ASSERT_IMPL(a_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "out held")
  `RVX_ASSERT_IMPL(a_nowr_zero, clk, rst_n, out_valid && !out_data.reg_write |-> out_data.dest_reg == 5'd0 && out_data.dest_value == 32'd0, "dest not zero")
  `RVX_ASSERT_IMPL(a_ill_nowr, clk, rst_n, out_valid && out_data.status == ST_ILLEGAL |-> !out_data.reg_write, "illegal wrote")

endmodule

bind rv32i_instruction_execute rvx_checker u_rvx_checker (.*);

// ===== tb/rv32i_instruction_execute_checker.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_execute_checker: transaction predictor and comparator
// Watches both channels, keeps its own copy of the PC, register file and
// data memory, and checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_checker
  import rvx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  output int         errors,
  output int         outstanding
);

  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4, F3_HU = 3'd5;

  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic [7:0]  dmem [MEM_BYTES];
  out_item_t   result_q [$];
  int          mism;

  assign errors = mism;
  assign outstanding = result_q.size();

  function automatic logic fits(logic [31:0] addr, logic [31:0] size);
    return addr <= MEM_BYTES - size;
  endfunction

  function automatic logic [31:0] mem_rd(logic [31:0] addr, int size);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < size; i++) v |= 32'(dmem[addr + i]) << (8 * i);
    return v;
  endfunction

  function automatic void mem_wr(logic [31:0] addr, int size, logic [31:0] v);
    for (int i = 0; i < size; i++) dmem[addr + i] = v[8*i +: 8];
  endfunction

  // ALU for both OP and OP-IMM forms; returns 0 for an undefined encoding
  function automatic logic alu(logic [2:0] f3, logic [6:0] f7, logic imm_form,
                               logic [31:0] a, logic [31:0] b, output logic [31:0] r);
    logic ok;
    ok = 1'b1;
    r = '0;
    case (f3)
      F3_ADD: if (imm_form || f7 == 7'd0) r = a + b;
              else if (f7 == F7_ALT) r = a - b;
              else ok = 1'b0;
      F3_SLL: if (f7 == 7'd0) r = a << b[4:0]; else ok = 1'b0;
      F3_SR:  if (f7 == 7'd0) r = a >> b[4:0];
              else if (f7 == F7_ALT) r = $signed(a) >>> b[4:0];
              else ok = 1'b0;
      default: begin
        if (!imm_form && f7 != 7'd0) ok = 1'b0;
        case (f3)
          F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
          F3_SLTU: r = {31'd0, a < b};
          F3_XOR:  r = a ^ b;
          F3_OR:   r = a | b;
          default: r = a & b;
        endcase
      end
    endcase
    return ok;
  endfunction

  function automatic out_item_t execute_item(in_item_t it);
    out_item_t   r;
    logic [31:0] ir, npc, a, b, imm_i, imm_s, imm_b, imm_j, ea, v, val;
    logic [1:0]  st;
    logic        wr, take;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    int          size;
    r = '0;
    st = ST_OK;
    wr = 1'b0;
    val = '0;
    ir = it.instruction;
    f3 = ir[14:12];
    f7 = ir[31:25];
    rd = ir[11:7];
    case (opn_t'(it.operation))
      OPN_WRITE: if (fits(32'(it.mem_address), 4)) mem_wr(32'(it.mem_address), 4, it.mem_word);
                 else st = ST_RANGE;
      OPN_READ:  if (fits(32'(it.mem_address), 4)) r.read_word = mem_rd(32'(it.mem_address), 4);
                 else st = ST_RANGE;
      OPN_EXEC: begin
        npc = pc_q + 32'd4;
        a = gpr[ir[19:15]];
        b = gpr[ir[24:20]];
        imm_i = {{20{ir[31]}}, ir[31:20]};
        imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
        imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
        imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
        case (ir[6:0])
          OPC_LUI:   begin wr = 1'b1; val = {ir[31:12], 12'd0}; end
          OPC_AUIPC: begin wr = 1'b1; val = pc_q + {ir[31:12], 12'd0}; end
          OPC_JAL:   begin wr = 1'b1; val = pc_q + 32'd4; npc = pc_q + imm_j; end
          OPC_JALR:
            if (f3 != 3'd0) st = ST_ILLEGAL;
            else begin
              wr = 1'b1; val = pc_q + 32'd4; npc = (a + imm_i) & ~32'd1;
            end
          OPC_BRANCH: begin
            take = 1'b0;
            case (f3)
              F3_BEQ:  take = a == b;
              F3_BNE:  take = a != b;
              F3_BLT:  take = $signed(a) < $signed(b);
              F3_BGE:  take = $signed(a) >= $signed(b);
              F3_BLTU: take = a < b;
              F3_BGEU: take = a >= b;
              default: st = ST_ILLEGAL;
            endcase
            if (take) npc = pc_q + imm_b;
          end
          OPC_LOAD:
            if (!(f3 inside {F3_B, F3_H, F3_W, F3_BU, F3_HU})) st = ST_ILLEGAL;
            else begin
              size = (f3[1:0] == 2'd0) ? 1 : (f3[1:0] == 2'd1) ? 2 : 4;
              ea = a + imm_i;
              v = '0;
              if (fits(ea, size)) v = mem_rd(ea, size);
              else st = ST_RANGE;
              if (f3 == F3_B) v = {{24{v[7]}}, v[7:0]};
              else if (f3 == F3_H) v = {{16{v[15]}}, v[15:0]};
              wr = 1'b1; val = v;
            end
          OPC_STORE:
            if (f3 > F3_W) st = ST_ILLEGAL;
            else begin
              size = (f3 == F3_B) ? 1 : (f3 == F3_H) ? 2 : 4;
              ea = a + imm_s;
              if (fits(ea, size)) mem_wr(ea, size, b);
              else st = ST_RANGE;
            end
          OPC_IMM:
            if (f3 == F3_SLL || f3 == F3_SR) begin
              if (alu(f3, f7, 1'b1, a, 32'(ir[24:20]), v)) begin wr = 1'b1; val = v; end
              else st = ST_ILLEGAL;
            end else begin
              void'(alu(f3, 7'd0, 1'b1, a, imm_i, v));
              wr = 1'b1; val = v;
            end
          OPC_REG:
            if (alu(f3, f7, 1'b0, a, b, v)) begin wr = 1'b1; val = v; end
            else st = ST_ILLEGAL;
          default: st = ST_ILLEGAL;
        endcase
        if (st == ST_ILLEGAL || rd == 5'd0) wr = 1'b0;
        if (wr) gpr[rd] = val;
        pc_q = npc;
        r.reg_write = wr;
        r.dest_reg = wr ? rd : 5'd0;
        r.dest_value = wr ? val : 32'd0;
      end
      default: ;
    endcase
    r.next_pc = pc_q;
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      pc_q = '0;
      result_q.delete();
      mism = 0;
    end else begin
      if (in_valid && in_ready) result_q.push_back(execute_item(in_data));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result transaction %h", out_data);
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.next_pc !== out_data.next_pc || exp_r.reg_write !== out_data.reg_write ||
              exp_r.dest_reg !== out_data.dest_reg ||
              exp_r.dest_value !== out_data.dest_value ||
              exp_r.read_word !== out_data.read_word || exp_r.status !== out_data.status) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: exp pc=%h wr=%b rd=%0d val=%h rw=%h st=%0d / ",
                       exp_r.next_pc, exp_r.reg_write, exp_r.dest_reg, exp_r.dest_value,
                       exp_r.read_word, exp_r.status,
                       "act pc=%h wr=%b rd=%0d val=%h rw=%h st=%0d",
                       out_data.next_pc, out_data.reg_write, out_data.dest_reg,
                       out_data.dest_value, out_data.read_word, out_data.status);
          end
        end
      end
    end
  end

endmodule

// ===== tb/rv32i_instruction_execute_tb.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_execute_tb: stimulus and verdict for the RV32I executor
// Fills data memory, runs directed corner instructions, then random
// instruction streams under four idle/stall phases; the checker predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute_tb;
  import rvx_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        errors, outstanding;
  int        idle_pct, stall_pct;

  always #10 clk = ~clk;

  rv32i_instruction_execute u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rv32i_instruction_execute_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .outstanding(outstanding)
  );

  // Receiver: random backpressure, one decision per falling edge
  always @(negedge clk)
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);

  // Drive one transaction; valid holds until the handshake. Idle cycles
  // before it drop valid, each on its own falling edge.
  task automatic send(opn_t op, logic [31:0] ir, logic [11:0] addr, logic [31:0] word);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{operation: op, instruction: ir, mem_address: addr, mem_word: word};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic exec(logic [31:0] ir);
    send(OPN_EXEC, ir, 12'($urandom), $urandom);
  endtask

  // Base register: mostly x1..x3, otherwise any register
  function automatic logic [4:0] pick_base();
    return ($urandom_range(9) < 7) ? 5'($urandom_range(1, 3)) : 5'($urandom);
  endfunction

  // Random well-formed-ish instruction with random content
  function automatic logic [31:0] rand_instr();
    logic [31:0] r;
    logic [6:0]  opc, f7;
    logic [11:0] imm;
    r = $urandom;
    f7 = ($urandom_range(9) < 8) ? (($urandom_range(1)) ? F7_ALT : 7'd0) : 7'($urandom);
    imm = ($urandom_range(1)) ? 12'($urandom_range(0, 2047)) : 12'($urandom);
    case ($urandom_range(11))
      0: opc = OPC_LUI;
      1: opc = OPC_AUIPC;
      2: opc = OPC_JAL;
      3: opc = OPC_JALR;
      4: opc = OPC_BRANCH;
      5, 6: opc = OPC_LOAD;
      7: opc = OPC_STORE;
      8: opc = OPC_IMM;
      9: opc = OPC_REG;
      10: return r;
      default: return {imm, 5'd0, 3'd0, 5'($urandom_range(1, 3)), OPC_IMM};
    endcase
    r[6:0] = opc;
    if (opc == OPC_LOAD || opc == OPC_JALR) r[31:15] = {imm, pick_base()};
    else if (opc == OPC_STORE) begin
      r[31:25] = imm[11:5];
      r[11:7] = imm[4:0];
      r[19:15] = pick_base();
    end else if (opc == OPC_REG || (opc == OPC_IMM && r[13:12] == 2'b01)) r[31:25] = f7;
    if (opc == OPC_JALR && $urandom_range(3) != 0) r[14:12] = 3'd0;
    return r;
  endfunction

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every memory word gets a value before anything reads it
    for (int w = 0; w < MEM_WORDS; w++) send(OPN_WRITE, $urandom, 12'(w * 4), $urandom);

    // Directed: extremes, each operation, range edges, x0, illegal forms
    exec({20'hfffff, 5'd1, OPC_LUI});
    exec({20'h80000, 5'd2, OPC_AUIPC});
    exec({12'h7ff, 5'd0, 3'd0, 5'd3, OPC_IMM});                     // x3 = 2047
    exec({12'hfff, 5'd0, 3'd0, 5'd4, OPC_IMM});                     // x4 = -1
    exec({12'h000, 5'd0, 3'd0, 5'd0, OPC_IMM});                     // write to x0
    exec({7'd0, 5'd4, 5'd3, 3'd2, 5'd5, OPC_REG});                  // slt 2047 < -1
    exec({7'd0, 5'd4, 5'd3, 3'd3, 5'd6, OPC_REG});                  // sltu
    exec({F7_ALT, 5'd31, 5'd4, 3'd5, 5'd7, OPC_IMM});               // srai by 31
    exec({F7_ALT, 5'd3, 5'd4, 3'd0, 5'd8, OPC_REG});                // sub
    exec({12'h7fd, 5'd3, 3'd2, 5'd9, OPC_LOAD});                    // lw at 4092
    exec({12'h7fe, 5'd3, 3'd2, 5'd9, OPC_LOAD});                    // lw past end
    exec({12'h7ff, 5'd3, 3'd0, 5'd10, OPC_LOAD});                   // lb at 4094
    exec({12'h7ff, 5'd3, 3'd5, 5'd10, OPC_LOAD});                   // lhu at 4094
    exec({7'h3f, 5'd4, 5'd3, 3'd1, 5'h1f, OPC_STORE});              // sh at 4094
    exec({7'h3f, 5'd4, 5'd3, 3'd0, 5'h1e, OPC_STORE});              // sb at 4093
    exec({7'd0, 5'd4, 5'd3, 3'd7, 5'd8, OPC_BRANCH});               // bgeu not taken
    exec({7'd0, 5'd3, 5'd4, 3'd5, 5'd8, OPC_BRANCH});               // bge not taken
    exec({7'd0, 5'd3, 5'd3, 3'd2, 5'd8, OPC_BRANCH});               // illegal branch
    exec({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd1, OPC_JAL});              // jal -2
    exec({12'h7ff, 5'd3, 3'd0, 5'd11, OPC_JALR});                   // even target 4094
    exec({12'h000, 5'd3, 3'd1, 5'd11, OPC_JALR});                   // jalr bad funct3
    exec({7'h01, 5'd3, 5'd3, 3'd1, 5'd12, OPC_IMM});                // bad slli funct7
    exec(32'hffff_ffff);                                            // unknown opcode
    send(OPN_WRITE, '0, 12'd4093, 32'hdead_beef);
    send(OPN_READ, '0, 12'd4092, '0);
    send(OPN_READ, '0, 12'd4095, '0);
    send(OPN_NONE, $urandom, 12'($urandom), $urandom);

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 81 : (ph == 3) ? 35 : 0;
      stall_pct = (ph == 2) ? 81 : (ph == 3) ? 35 : 0;
      for (int n = 0; n < 200; n++) begin
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) exec(rand_instr());
        else if (sel < 89) send(OPN_WRITE, $urandom, 12'($urandom), $urandom);
        else if (sel < 98) send(OPN_READ, $urandom, 12'($urandom), $urandom);
        else send(OPN_NONE, $urandom, 12'($urandom), $urandom);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    stall_pct = 0;

    // Drain, then wait out any stray result
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog well past the slowest legal run
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
